### rtl/core/wis_pkg.sv
package wis_pkg;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 6;
    localparam int WEIGHT_W   = 16;
    localparam int FRAC_W     = 32;
    localparam int PICK_W     = 17;
    localparam int BASE_W     = 16;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_ENTRIES       = 64;
    localparam int DEF_WEIGHT_BITS   = 16;
    localparam int DEF_FRACTION_BITS = 32;

    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_CLEAR = 2'd0;
    localparam op_t OP_WRITE = 2'd1;
    localparam op_t OP_BUILD = 2'd2;
    localparam op_t OP_PICK  = 2'd3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_BASE_OFFSET = 1'd0;
    localparam cfg_idx_t CFG_ENTRY_COUNT = 1'd1;

    typedef logic [1:0] sweep_t;
    localparam sweep_t SW_ANY   = 2'd0;
    localparam sweep_t SW_SUM   = 2'd1;
    localparam sweep_t SW_TOTAL = 2'd2;
    localparam sweep_t SW_COUNT = 2'd3;

    typedef struct packed {
        sweep_t mode;
        logic   clear;
        logic   flat;
    } cell_ctl_t;

    typedef struct packed {
        logic we;
        logic active;
        logic cmp_en;
        logic is_last;
    } cell_sel_t;

endpackage

### rtl/core/wis_item_if.sv
interface wis_item_if;
    logic                        valid;
    logic                        ready;
    logic [wis_pkg::OP_W-1:0]     operation;
    logic [wis_pkg::IDX_W-1:0]    entry_index;
    logic [wis_pkg::WEIGHT_W-1:0] weight;
    logic [wis_pkg::FRAC_W-1:0]   fraction;

    modport source (output valid, operation, entry_index, weight, fraction, input ready);
    modport sink (input valid, operation, entry_index, weight, fraction, output ready);
endinterface

### rtl/core/wis_result_if.sv
interface wis_result_if;
    logic                      valid;
    logic                      ready;
    logic [wis_pkg::PICK_W-1:0] picked_index;
    logic                      flat_in_use;

    modport source (output valid, picked_index, flat_in_use, input ready);
    modport sink (input valid, picked_index, flat_in_use, output ready);
endinterface

### rtl/core/wis_cfg_if.sv
interface wis_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [wis_pkg::CFG_IDX_W-1:0]  index;
    logic [wis_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/wis_cell.sv
module wis_cell #(
    parameter int WEIGHT_BITS = wis_pkg::DEF_WEIGHT_BITS,
    parameter int CUM_BITS    = wis_pkg::DEF_WEIGHT_BITS + 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wis_pkg::cell_ctl_t     ctl,
    input  wis_pkg::cell_sel_t     sel,
    input  logic [WEIGHT_BITS-1:0] wdata,
    input  logic [CUM_BITS-1:0]    v,
    input  logic                   tok_in_valid,
    input  logic [CUM_BITS-1:0]    tok_in_data,
    output logic                   tok_out_valid,
    output logic [CUM_BITS-1:0]    tok_out_data
);

    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [CUM_BITS-1:0]    cum_reg, cum_next;
    logic                   tok_valid_reg;
    logic [CUM_BITS-1:0]    tok_data_reg, tok_data_next;
    logic [WEIGHT_BITS-1:0] w_eff;
    logic [CUM_BITS-1:0]    sum;

    always_comb
    begin
        w_eff         = ctl.flat ? WEIGHT_BITS'(1) : w_reg;
        sum           = tok_in_data + CUM_BITS'(w_eff);
        w_next        = w_reg;
        cum_next      = cum_reg;
        tok_data_next = tok_in_data;
        if (ctl.clear)
        begin
            w_next = '0;
        end
        else if (sel.we)
        begin
            w_next = wdata;
        end
        if (tok_in_valid)
        begin
            unique case (ctl.mode)
                wis_pkg::SW_ANY:
                begin
                    tok_data_next = tok_in_data | CUM_BITS'(sel.active && (w_reg != '0));
                end
                wis_pkg::SW_SUM:
                begin
                    if (sel.active)
                    begin
                        w_next        = w_eff;
                        cum_next      = sum;
                        tok_data_next = sum;
                    end
                end
                wis_pkg::SW_TOTAL:
                begin
                    if (sel.is_last)
                    begin
                        tok_data_next = cum_reg;
                    end
                end
                wis_pkg::SW_COUNT:
                begin
                    tok_data_next = tok_in_data + CUM_BITS'(sel.cmp_en && (cum_reg <= v));
                end
                default:
                begin
                    tok_data_next = tok_in_data;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= '0;
            cum_reg       <= '0;
            tok_valid_reg <= 1'b0;
            tok_data_reg  <= '0;
        end
        else
        begin
            w_reg         <= w_next;
            cum_reg       <= cum_next;
            tok_valid_reg <= tok_in_valid;
            tok_data_reg  <= tok_data_next;
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out_data  = tok_data_reg;

endmodule

### rtl/core/wis_scale.sv
module wis_scale #(
    parameter int FRACTION_BITS = wis_pkg::DEF_FRACTION_BITS,
    parameter int CUM_BITS      = wis_pkg::DEF_WEIGHT_BITS + 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [FRACTION_BITS-1:0] fraction,
    input  logic [CUM_BITS-1:0]      total,
    output logic                     done,
    output logic [CUM_BITS-1:0]      v
);

    localparam int PAD_W = (CUM_BITS > 32) ? CUM_BITS : 33;
    localparam int HI_W  = PAD_W - 32;
    localparam int LO_W  = FRACTION_BITS + 32;
    localparam int PH_W  = FRACTION_BITS + HI_W;
    localparam int SUM_W = FRACTION_BITS + PAD_W;

    logic [PAD_W-1:0]    total_pad;
    logic [31:0]         tl;
    logic [HI_W-1:0]     th;
    logic [LO_W-1:0]     lo_reg, lo_next;
    logic [PH_W-1:0]     hi_reg, hi_next;
    logic [SUM_W-1:0]    wide;
    logic                s1_valid_reg, s2_valid_reg;
    logic [CUM_BITS-1:0] v_reg, v_next;

    assign total_pad = PAD_W'(total);
    assign tl        = total_pad[31:0];
    assign th        = total_pad[PAD_W-1:32];
    assign lo_next   = LO_W'(fraction) * LO_W'(tl);
    assign hi_next   = PH_W'(fraction) * PH_W'(th);
    assign wide      = (SUM_W'(lo_reg) >> FRACTION_BITS) + (SUM_W'(hi_reg) << (32 - FRACTION_BITS));
    assign v_next    = wide[CUM_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        v_reg  <= v_next;
    end

    assign done = s2_valid_reg;
    assign v    = v_reg;

endmodule

### rtl/core/weighted_index_sampler.sv
// Clear and write-weight items complete in the idle state; build and pick pass a token along the
// row of ENTRIES cells twice, one cell per cycle.
// Build sweeps the row to test for any weight, then to form the sums. Pick sweeps for the total,
// scales it in a registered multiply, then sweeps to count sums. One item is worked at a time.
// Reset clears all weights, sums, the flat flag and both registers; no clearing pass.
module weighted_index_sampler #(
    parameter int ENTRIES       = wis_pkg::DEF_ENTRIES,
    parameter int WEIGHT_BITS   = wis_pkg::DEF_WEIGHT_BITS,
    parameter int FRACTION_BITS = wis_pkg::DEF_FRACTION_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    wis_item_if.sink     item,
    wis_result_if.source result,
    wis_cfg_if.sink      cfg
);

    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int CUM_BITS = WEIGHT_BITS + CNT_W;
    localparam int CMP_W    = (CNT_W > wis_pkg::COUNT_W) ? CNT_W : wis_pkg::COUNT_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ANY   = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_TOTAL = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_COUNT = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]                   state_reg, state_next;
    wis_pkg::sweep_t              mode_reg, mode_next;
    logic                         launch_reg, launch_next;
    logic                         flat_reg, flat_next;
    logic [CUM_BITS-1:0]          total_reg, total_next;
    logic [CUM_BITS-1:0]          v_reg, v_next;
    logic [FRACTION_BITS-1:0]     frac_reg, frac_next;
    logic [CNT_W-1:0]             x_reg, x_next;
    logic                         start_reg, start_next;
    logic                         out_valid_reg, out_valid_next;
    logic [wis_pkg::PICK_W-1:0]   pick_reg, pick_next;
    logic                         oflat_reg, oflat_next;
    logic [wis_pkg::BASE_W-1:0]   base_reg, base_next;
    logic [wis_pkg::COUNT_W-1:0]  count_reg, count_next;

    logic                         item_fire;
    logic                         cfg_fire;
    logic [CMP_W-1:0]             count_ext;
    logic [CNT_W-1:0]             n_used;
    logic                         chain_done;
    logic                         scale_done;
    logic [CUM_BITS-1:0]          scale_v;
    logic [WEIGHT_BITS-1:0]       wdata;
    wis_pkg::cell_ctl_t           ctl;

    logic                         tok_v [0:ENTRIES];
    logic [CUM_BITS-1:0]          tok_d [0:ENTRIES];

    assign item_fire  = item.valid && item.ready;
    assign cfg_fire   = cfg.valid && cfg.ready;
    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    assign count_ext = CMP_W'(count_reg);
    assign n_used    = (count_ext > CMP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(count_ext);

    assign wdata      = WEIGHT_BITS'(item.weight);
    assign ctl.mode   = mode_reg;
    assign ctl.clear  = item_fire && (item.operation == wis_pkg::OP_CLEAR);
    assign ctl.flat   = flat_reg;

    assign tok_v[0]   = launch_reg;
    assign tok_d[0]   = '0;
    assign chain_done = tok_v[ENTRIES];

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        wis_pkg::cell_sel_t sel;

        assign sel.we      = item_fire && (item.operation == wis_pkg::OP_WRITE)
                             && (g < (1 << wis_pkg::IDX_W))
                             && (item.entry_index == wis_pkg::IDX_W'(g));
        assign sel.active  = (CNT_W'(g) < n_used);
        assign sel.cmp_en  = (CNT_W'(g + 1) < n_used);
        assign sel.is_last = (CNT_W'(g + 1) == n_used);

        wis_cell #(
            .WEIGHT_BITS (WEIGHT_BITS),
            .CUM_BITS    (CUM_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .sel           (sel),
            .wdata         (wdata),
            .v             (v_reg),
            .tok_in_valid  (tok_v[g]),
            .tok_in_data   (tok_d[g]),
            .tok_out_valid (tok_v[g+1]),
            .tok_out_data  (tok_d[g+1])
        );
    end

    wis_scale #(
        .FRACTION_BITS (FRACTION_BITS),
        .CUM_BITS      (CUM_BITS)
    ) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .fraction (frac_reg),
        .total    (total_reg),
        .done     (scale_done),
        .v        (scale_v)
    );

    always_comb
    begin
        base_next  = base_reg;
        count_next = count_reg;
        if (cfg_fire)
        begin
            unique case (cfg.index)
                wis_pkg::CFG_BASE_OFFSET: base_next  = cfg.data[wis_pkg::BASE_W-1:0];
                wis_pkg::CFG_ENTRY_COUNT: count_next = cfg.data[wis_pkg::COUNT_W-1:0];
                default:                  base_next  = base_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        launch_next    = 1'b0;
        flat_next      = flat_reg;
        total_next     = total_reg;
        v_next         = v_reg;
        frac_next      = frac_reg;
        x_next         = x_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg && !result.ready;
        pick_next      = pick_reg;
        oflat_next     = oflat_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    unique case (item.operation)
                        wis_pkg::OP_BUILD:
                        begin
                            mode_next   = wis_pkg::SW_ANY;
                            launch_next = 1'b1;
                            state_next  = ST_ANY;
                        end
                        wis_pkg::OP_PICK:
                        begin
                            frac_next   = FRACTION_BITS'(item.fraction);
                            mode_next   = wis_pkg::SW_TOTAL;
                            launch_next = 1'b1;
                            state_next  = ST_TOTAL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ANY:
            begin
                if (chain_done)
                begin
                    flat_next   = !tok_d[ENTRIES][0];
                    mode_next   = wis_pkg::SW_SUM;
                    launch_next = 1'b1;
                    state_next  = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (chain_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TOTAL:
            begin
                if (chain_done)
                begin
                    total_next = tok_d[ENTRIES];
                    start_next = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (scale_done)
                begin
                    v_next      = scale_v;
                    mode_next   = wis_pkg::SW_COUNT;
                    launch_next = 1'b1;
                    state_next  = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (chain_done)
                begin
                    if ((n_used < CNT_W'(2)) || (total_reg == '0))
                    begin
                        x_next = '0;
                    end
                    else
                    begin
                        x_next = tok_d[ENTRIES][CNT_W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    pick_next      = wis_pkg::PICK_W'(base_reg) + wis_pkg::PICK_W'(x_reg);
                    oflat_next     = flat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= wis_pkg::SW_ANY;
            launch_reg    <= 1'b0;
            flat_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            launch_reg    <= launch_next;
            flat_reg      <= flat_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            base_reg      <= base_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        v_reg     <= v_next;
        frac_reg  <= frac_next;
        x_reg     <= x_next;
        pick_reg  <= pick_next;
        oflat_reg <= oflat_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.picked_index = pick_reg;
    assign result.flat_in_use  = oflat_reg;

endmodule

### sim/tb_weighted_index_sampler.sv
`timescale 1ns / 1ps

class index_picker_model;
    typedef struct {
        logic [wis_pkg::PICK_W-1:0] picked;
        logic                       flat;
    } pick_t;

    logic [wis_pkg::WEIGHT_W-1:0] weights[64];
    logic [21:0]                  sums[65];
    logic                         flat_flag;
    logic [wis_pkg::BASE_W-1:0]   base_offset;
    logic [wis_pkg::COUNT_W-1:0]  entry_count;
    pick_t                        expected_picks[$];
    int unsigned                  mismatches;
    int unsigned                  picks_checked;
    int unsigned                  flat_picks;
    int unsigned                  builds;

    function new();
        foreach (weights[i]) weights[i] = '0;
        foreach (sums[i]) sums[i] = '0;
        flat_flag     = 1'b0;
        base_offset   = '0;
        entry_count   = '0;
        mismatches    = 0;
        picks_checked = 0;
        flat_picks    = 0;
        builds        = 0;
    endfunction

    function void set_register(wis_pkg::cfg_idx_t idx, logic [wis_pkg::CFG_DATA_W-1:0] data);
        if (idx == wis_pkg::CFG_BASE_OFFSET)
            base_offset = data;
        else
            entry_count = data[wis_pkg::COUNT_W-1:0];
    endfunction

    function int unsigned used_entries();
        return (entry_count > 64) ? 64 : int'(entry_count);
    endfunction

    function void build_sums();
        int unsigned n;
        bit          any;
        n   = used_entries();
        any = 1'b0;
        for (int unsigned i = 0; i < n; i++)
            if (weights[i] != '0)
                any = 1'b1;
        if (!any)
        begin
            for (int unsigned i = 0; i < n; i++)
                weights[i] = 16'd1;
            flat_flag = 1'b1;
        end
        else
        begin
            flat_flag = 1'b0;
        end
        sums[0] = '0;
        for (int unsigned i = 0; i < n; i++)
            sums[i + 1] = sums[i] + 22'(weights[i]);
        builds++;
    endfunction

    function int unsigned choose_entry(logic [wis_pkg::FRAC_W-1:0] frac);
        int unsigned n;
        logic [63:0] total;
        logic [63:0] scaled;
        int unsigned x;
        n = used_entries();
        if (n < 2)
            return 0;
        total = 64'(sums[n]);
        if (total == 0)
            return 0;
        scaled = (64'(frac) * total) >> 32;
        x = 0;
        for (int unsigned i = 1; i < n; i++)
            if (64'(sums[i]) <= scaled)
                x++;
        return x;
    endfunction

    function void apply_item(wis_pkg::op_t op, logic [wis_pkg::IDX_W-1:0] idx,
                             logic [wis_pkg::WEIGHT_W-1:0] w, logic [wis_pkg::FRAC_W-1:0] frac);
        pick_t next;
        case (op)
            wis_pkg::OP_CLEAR:
                foreach (weights[i]) weights[i] = '0;
            wis_pkg::OP_WRITE:
                weights[idx] = w;
            wis_pkg::OP_BUILD:
                build_sums();
            default:
            begin
                next.picked = wis_pkg::PICK_W'(base_offset) + wis_pkg::PICK_W'(choose_entry(frac));
                next.flat   = flat_flag;
                expected_picks.push_back(next);
            end
        endcase
    endfunction

    function void check_pick(logic [wis_pkg::PICK_W-1:0] picked, logic flat);
        pick_t want;
        if (expected_picks.size() == 0)
        begin
            $error("unexpected result: picked_index %0d, flat_in_use %0d", picked, flat);
            mismatches++;
            return;
        end
        want = expected_picks.pop_front();
        if (picked !== want.picked)
        begin
            $error("picked_index mismatch: expected %0d, actual %0d", want.picked, picked);
            mismatches++;
        end
        if (flat !== want.flat)
        begin
            $error("flat_in_use mismatch: expected %0d, actual %0d", want.flat, flat);
            mismatches++;
        end
        picks_checked++;
        if (want.flat)
            flat_picks++;
    endfunction
endclass

module tb_weighted_index_sampler;
    import wis_pkg::*;

    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int SETTLE_CYCLES = 2 * DEF_ENTRIES + 40;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 170;

    logic clk;
    logic rst_n;

    wis_item_if   item_bus();
    wis_result_if result_bus();
    wis_cfg_if    cfg_bus();

    weighted_index_sampler u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    index_picker_model picker;

    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    bit          gaps_on     = 1'b0;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  stall_pos     = 4'd0;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        stall_pos         <= stall_pos + 4'd1;
        result_bus.ready  <= stall_pattern[stall_pos];
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
            picker.check_pick(result_bus.picked_index, result_bus.flat_in_use);
    end

    task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic [WEIGHT_W-1:0] w,
                             logic [FRAC_W-1:0] frac);
        if (gaps_on && burst_left == 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 8))
                @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        item_bus.valid       <= 1'b1;
        item_bus.operation   <= op;
        item_bus.entry_index <= idx;
        item_bus.weight      <= w;
        item_bus.fraction    <= frac;
        do
            @(posedge clk);
        while (!item_bus.ready);
        picker.apply_item(op, idx, w, frac);
        items_sent++;
    endtask

    task automatic wait_idle();
        item_bus.valid <= 1'b0;
        burst_left = 0;
        while (picker.expected_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        picker.set_register(idx, data);
        @(posedge clk);
    endtask

    task automatic run_sequences(int unsigned quota);
        int unsigned sent_here;
        int unsigned n;
        int unsigned writes;
        int unsigned picks;
        int unsigned b;
        logic [63:0] total;
        logic [63:0] edge_frac;
        logic [FRAC_W-1:0] frac;
        logic [WEIGHT_W-1:0] w;
        logic [IDX_W-1:0] idx;
        sent_here = 0;
        n = picker.used_entries();
        while (sent_here < quota)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    send_item(OP_CLEAR, IDX_W'($urandom), WEIGHT_W'($urandom), $urandom);
                    sent_here++;
                end
                writes = $urandom_range(0, (n > 0) ? n : 4);
                for (int unsigned k = 0; k < writes; k++)
                begin
                    case ($urandom_range(0, 4))
                        0: w = '0;
                        1: w = WEIGHT_W'($urandom_range(1, 8));
                        2: w = '1;
                        default: w = WEIGHT_W'($urandom);
                    endcase
                    if (n > 0 && $urandom_range(0, 7) != 0)
                        idx = IDX_W'($urandom_range(0, n - 1));
                    else
                        idx = IDX_W'($urandom);
                    send_item(OP_WRITE, idx, w, $urandom);
                    sent_here++;
                end
                if ($urandom_range(0, 5) != 0)
                begin
                    send_item(OP_BUILD, IDX_W'($urandom), WEIGHT_W'($urandom), $urandom);
                    sent_here++;
                end
                picks = $urandom_range(1, 6);
                for (int unsigned k = 0; k < picks; k++)
                begin
                    total = 64'(picker.sums[n]);
                    case ($urandom_range(0, 5))
                        0: frac = '0;
                        1: frac = '1;
                        2, 3:
                        begin
                            // aim at a sum boundary: first fraction reaching it, or one below
                            if (n >= 2 && total != 0)
                            begin
                                b = $urandom_range(1, n - 1);
                                if (64'(picker.sums[b]) >= total)
                                    frac = '1;
                                else
                                begin
                                    edge_frac = ((64'(picker.sums[b]) << 32) + total - 1) / total;
                                    frac = FRAC_W'(edge_frac) - FRAC_W'($urandom_range(0, 1));
                                end
                            end
                            else
                                frac = $urandom;
                        end
                        default: frac = $urandom;
                    endcase
                    send_item(OP_PICK, IDX_W'($urandom), WEIGHT_W'($urandom), frac);
                    sent_here++;
                end
            end
            else
            begin
                send_item(op_t'($urandom_range(0, 3)), IDX_W'($urandom), WEIGHT_W'($urandom),
                          $urandom);
                sent_here++;
            end
        end
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] count_data;
        logic [CFG_DATA_W-1:0] offset_data;

        picker = new();
        rst_n                = 1'b0;
        item_bus.valid       = 1'b0;
        item_bus.operation   = OP_CLEAR;
        item_bus.entry_index = '0;
        item_bus.weight      = '0;
        item_bus.fraction    = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = CFG_BASE_OFFSET;
        cfg_bus.data         = '0;
        result_bus.ready     = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no entries in use yet
        send_item(OP_PICK, 6'h2A, 16'h5555, 32'h0);
        wait_idle();
        write_register(CFG_BASE_OFFSET, 16'hFFFF);
        write_register(CFG_ENTRY_COUNT, 16'd4);

        // nothing built for this count
        send_item(OP_PICK, 6'h15, 16'hAAAA, 32'h8000_0000);
        send_item(OP_WRITE, 6'd0, 16'h0000, 32'hFFFF_FFFF);
        send_item(OP_WRITE, 6'd1, 16'hFFFF, 32'h0);
        send_item(OP_WRITE, 6'd2, 16'h0001, 32'h0);
        send_item(OP_WRITE, 6'd3, 16'h0000, 32'h0);
        send_item(OP_WRITE, 6'd63, 16'hFFFF, 32'h0);
        send_item(OP_BUILD, 6'h3F, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_PICK, 6'h00, 16'h0000, 32'h0000_0000);
        send_item(OP_PICK, 6'h3F, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_PICK, 6'h00, 16'h0000, 32'hFFFE_FFFF);
        send_item(OP_PICK, 6'h00, 16'h0000, 32'hFFFF_0000);
        send_item(OP_PICK, 6'h00, 16'h0000, 32'h8000_0000);
        // stale sums survive a clear
        send_item(OP_CLEAR, 6'h3F, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_PICK, 6'h00, 16'h0000, 32'h1234_5678);
        // all zero: flat fallback
        send_item(OP_BUILD, 6'h00, 16'h0000, 32'h0);
        send_item(OP_PICK, 6'h00, 16'h0000, 32'hC000_0000);
        send_item(OP_PICK, 6'h00, 16'h0000, 32'h3FFF_FFFF);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: count_data = 16'd64;
                1: count_data = 16'd2;
                2: count_data = 16'd1;
                3: count_data = 16'd0;
                4: count_data = 16'd127;
                5: count_data = 16'd65;
                6: count_data = 16'($urandom);
                default: count_data = 16'($urandom_range(3, 64));
            endcase
            case (p % 3)
                0: offset_data = '0;
                1: offset_data = '1;
                default: offset_data = 16'($urandom);
            endcase
            if (p % 2 == 0)
            begin
                write_register(CFG_ENTRY_COUNT, count_data);
                write_register(CFG_BASE_OFFSET, offset_data);
            end
            else
            begin
                write_register(CFG_BASE_OFFSET, offset_data);
                write_register(CFG_ENTRY_COUNT, count_data);
            end
            gaps_on = (p % 3 != 2);
            case (p % 4)
                0: stall_pattern = 16'hFFFF;
                1: stall_pattern = 16'($urandom) | 16'h0001;
                2: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
                default: stall_pattern = 16'($urandom) | 16'($urandom);
            endcase
            run_sequences(PHASE_ITEMS);
            wait_idle();
        end

        $display("Sent %0d items with %0d builds; checked %0d picks, %0d under the flat fallback.",
                 items_sent, picker.builds, picker.picks_checked, picker.flat_picks);
        $display("Ran %0d register settings, entry counts 0 to 127 and offsets 0 to 65535.",
                 PHASES + 1);
        if (picker.mismatches == 0 && picker.expected_picks.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
